>>> src/plgm_pkg.sv
`timescale 1ns / 1ps

package plgm_pkg;

  // Data path widths fixed by the item fields.
  localparam int DATA_W      = 16;
  localparam int POINT_IDX_W = 4;
  localparam int CP_W        = 5;
  localparam int TRAVEL_W    = 15;

  // Calibration table depth and the widths that follow from it.
  localparam int CURVE_MAX = 16;
  localparam int CURVE_AW  = (CURVE_MAX > 1) ? $clog2(CURVE_MAX) : 1;
  localparam int N_W       = $clog2(CURVE_MAX + 1);

  // Shared multiply/divide unit.
  localparam int OPD_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * OPD_W;
  localparam int MAG_W     = 2 * DATA_W;
  localparam int MD_CNT_W  = $clog2(MAG_W);

  // Configuration port.
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_OWN_ID      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_MASK  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURVE_PTS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_TRAVEL  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TRAVEL  = 3'd5;

  localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  typedef logic [DATA_W-1:0]           data_t;
  typedef logic [CURVE_AW-1:0]         idx_t;
  typedef logic [N_W-1:0]              cnt_t;
  typedef logic signed [OPD_W-1:0]     opd_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic [MD_CNT_W-1:0]         mdcnt_t;

  typedef struct packed {
    logic [DATA_W-1:0]   own_control_id;
    logic [DATA_W-1:0]   value_mask;
    logic                reverse_input;
    logic [CP_W-1:0]     curve_points;
    logic [TRAVEL_W-1:0] min_travel;
    logic [TRAVEL_W-1:0] max_travel;
  } cfg_t;

  typedef struct packed {
    logic  start;
    opd_t  op_a;
    opd_t  op_b;
    data_t divisor;
  } md_req_t;

  typedef struct packed {
    logic  done;
    data_t quot;
  } md_rsp_t;

endpackage

>>> src/plgm_if.sv
`timescale 1ns / 1ps

interface plgm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [plgm_pkg::DATA_W-1:0]            control_id;
  logic [plgm_pkg::DATA_W-1:0]            value;
  logic [plgm_pkg::POINT_IDX_W-1:0]       point_index;
  logic [plgm_pkg::DATA_W-1:0]            point_in;
  logic [plgm_pkg::DATA_W-1:0]            point_out;

  modport source (output valid, command, control_id, value, point_index, point_in,
                  point_out, input ready);
  modport sink   (input valid, command, control_id, value, point_index, point_in,
                  point_out, output ready);
endinterface

interface plgm_out_if;
  logic                        valid;
  logic                        ready;
  logic [plgm_pkg::DATA_W-1:0] position;

  modport source (output valid, position, input ready);
  modport sink   (input valid, position, output ready);
endinterface

>>> src/piecewise_linear_gauge_map_top.sv
// Piecewise-linear gauge map. Each input item is either a load (command 0), which
// writes one calibration point into the curve tables, or a control packet (command 1),
// which yields one needle position when its id matches own_control_id. A load or a
// packet with a foreign id leaves the sequencer idle and yields no result. A matching
// packet is masked, optionally reversed, and then either clamped to the curve ends,
// or bracketed by a binary search over the curve (one table read per halving) and
// interpolated, or mapped linearly onto min_travel to max_travel when fewer than two
// curve points are configured. Interpolation and the linear map share one
// multiply/divide unit whose 32-step restoring divider sets the pace. The block
// accepts no item while one is being worked on, but a finished position sits in an
// output register, so the next item is taken while the result waits for the sink.
// Configuration must be written over the APB-style port only while the block is
// idle; the block itself does not enforce this; curve entries must be loaded before
// a curve that uses them is enabled.
`timescale 1ns / 1ps

module piecewise_linear_gauge_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  plgm_in_if.sink                       in_chan,
  plgm_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plgm_pkg::APB_AW-1:0]   paddr,
  input  logic [plgm_pkg::APB_DW-1:0]   pwdata,
  output logic [plgm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_CHKF  = 4'd2;
  localparam logic [3:0] S_CHKL  = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SETUP = 4'd6;
  localparam logic [3:0] S_LIN   = 4'd7;
  localparam logic [3:0] S_CALC  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  plgm_pkg::cfg_t     cfg;
  plgm_pkg::md_req_t  md_req;
  plgm_pkg::md_rsp_t  md_rsp;

  logic [3:0]         state_r, state_nxt;
  plgm_pkg::data_t    v_r;
  plgm_pkg::cnt_t     n_r;
  plgm_pkg::idx_t     lo_r, hi_r, mid_r;
  plgm_pkg::data_t    in_lo_r, in_hi_r, out_lo_r, out_hi_r;
  plgm_pkg::data_t    base_r;
  plgm_pkg::data_t    res_r;
  logic               out_valid_r;
  plgm_pkg::data_t    out_pos_r;

  logic               in_acc;
  logic               pkt_go;
  logic               slot_ok;
  plgm_pkg::data_t    v_masked;
  plgm_pkg::data_t    v_calc;
  plgm_pkg::cnt_t     n_calc;
  plgm_pkg::idx_t     last_idx;
  plgm_pkg::idx_t     mid;
  logic [plgm_pkg::CURVE_AW:0] idx_sum;
  plgm_pkg::idx_t     idx_gap;
  plgm_pkg::idx_t     rd_addr;
  plgm_pkg::data_t    rd_in, rd_out;
  logic               out_load;

  plgm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The calibration point is written at the edge that accepts the load item.
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign slot_ok = (32'(in_chan.point_index) < plgm_pkg::CURVE_MAX);

  plgm_curve u_curve (
    .clk     (clk),
    .wr_en   (in_acc && (in_chan.command == plgm_pkg::CMD_LOAD) && slot_ok),
    .wr_addr (plgm_pkg::idx_t'(in_chan.point_index)),
    .wr_in   (in_chan.point_in),
    .wr_out  (in_chan.point_out),
    .rd_addr (rd_addr),
    .rd_in   (rd_in),
    .rd_out  (rd_out)
  );

  plgm_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign pkt_go = in_acc && (in_chan.command == plgm_pkg::CMD_PACKET) &&
                  (in_chan.control_id == cfg.own_control_id);

  // Value conditioning and the number of curve points in use.
  assign v_masked = in_chan.value & cfg.value_mask;
  assign v_calc   = cfg.reverse_input ? (plgm_pkg::FULL_SCALE - v_masked) : v_masked;
  assign n_calc   = (32'(cfg.curve_points) > plgm_pkg::CURVE_MAX) ?
                    plgm_pkg::cnt_t'(plgm_pkg::CURVE_MAX) :
                    plgm_pkg::cnt_t'(cfg.curve_points);

  // Binary search bookkeeping; lo_r and hi_r always bracket the value.
  assign last_idx = plgm_pkg::idx_t'(n_r - plgm_pkg::cnt_t'(1));
  assign idx_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = idx_sum[plgm_pkg::CURVE_AW:1];
  assign idx_gap  = hi_r - lo_r;

  always_comb begin
    case (state_r)
      S_CHKF:  rd_addr = last_idx;
      S_SRCH:  rd_addr = mid;
      default: rd_addr = '0;
    endcase
  end

  // Operands for the shared unit: a curve segment or the linear travel range.
  always_comb begin
    md_req.start   = 1'b0;
    md_req.op_a    = $signed({1'b0, v_r}) - $signed({1'b0, in_lo_r});
    md_req.op_b    = $signed({1'b0, out_hi_r}) - $signed({1'b0, out_lo_r});
    md_req.divisor = in_hi_r - in_lo_r;
    if (state_r == S_LIN) begin
      md_req.start   = 1'b1;
      md_req.op_a    = $signed({1'b0, v_r});
      md_req.op_b    = $signed({2'b00, cfg.max_travel}) - $signed({2'b00, cfg.min_travel});
      md_req.divisor = plgm_pkg::FULL_SCALE;
    end else if (state_r == S_SETUP) begin
      md_req.start   = (in_hi_r != in_lo_r);
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pkt_go) begin
          state_nxt = (n_calc > plgm_pkg::cnt_t'(1)) ? S_FIRST : S_LIN;
        end
      end
      S_FIRST: state_nxt = S_CHKF;
      S_CHKF:  state_nxt = (v_r <= rd_in) ? S_DONE : S_CHKL;
      S_CHKL:  state_nxt = (v_r >= rd_in) ? S_DONE : S_SRCH;
      S_SRCH:  state_nxt = (idx_gap > plgm_pkg::idx_t'(1)) ? S_CMP : S_SETUP;
      S_CMP:   state_nxt = S_SRCH;
      S_SETUP: state_nxt = (in_hi_r == in_lo_r) ? S_DONE : S_CALC;
      S_LIN:   state_nxt = S_CALC;
      S_CALC:  if (md_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r <= res_r;
    end
    case (state_r)
      S_IDLE: begin
        v_r <= v_calc;
        n_r <= n_calc;
      end
      S_CHKF: begin
        in_lo_r  <= rd_in;
        out_lo_r <= rd_out;
        res_r    <= rd_out;
      end
      S_CHKL: begin
        in_hi_r  <= rd_in;
        out_hi_r <= rd_out;
        res_r    <= rd_out;
        lo_r     <= '0;
        hi_r     <= last_idx;
      end
      S_SRCH: begin
        mid_r <= mid;
      end
      S_CMP: begin
        if (v_r >= rd_in) begin
          lo_r     <= mid_r;
          in_lo_r  <= rd_in;
          out_lo_r <= rd_out;
        end else begin
          hi_r     <= mid_r;
          in_hi_r  <= rd_in;
          out_hi_r <= rd_out;
        end
      end
      S_SETUP: begin
        base_r <= out_lo_r;
        res_r  <= out_lo_r;
      end
      S_LIN: begin
        base_r <= plgm_pkg::DATA_W'(cfg.min_travel);
      end
      S_CALC: begin
        res_r <= base_r + md_rsp.quot;
      end
      default: ;
    endcase
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.position = out_pos_r;

`ifndef SYNTHESIS
  // A load item or a foreign packet never starts the sequencer.
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_chan.command == plgm_pkg::CMD_LOAD)) |=> (state_r == S_IDLE))
    else $error("load item left the sequencer busy");

  // The search bracket never collapses or inverts.
  a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SRCH) || (state_r == S_CMP)) |-> (lo_r < hi_r))
    else $error("search bracket lost its order");

  // The shared unit only reports back while the sequencer waits for it.
  a_md_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == S_CALC))
    else $error("multiply/divide finished outside the calculation state");

  // A handed-over result shows up in the output register unchanged.
  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (out_pos_r == $past(res_r))))
    else $error("result lost on the way to the output register");
`endif

endmodule

>>> src/plgm_cfg.sv
`timescale 1ns / 1ps

module plgm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plgm_pkg::APB_AW-1:0]     paddr,
  input  logic [plgm_pkg::APB_DW-1:0]     pwdata,
  output logic [plgm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output plgm_pkg::cfg_t                  cfg
);

  plgm_pkg::cfg_t                      cfg_r;
  logic [plgm_pkg::REG_IDX_W-1:0]      idx;
  logic                                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[plgm_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_control_id <= '0;
      cfg_r.value_mask     <= plgm_pkg::FULL_SCALE;
      cfg_r.reverse_input  <= 1'b0;
      cfg_r.curve_points   <= '0;
      cfg_r.min_travel     <= '0;
      cfg_r.max_travel     <= '0;
    end else if (wr_en) begin
      case (idx)
        plgm_pkg::REG_OWN_ID:     cfg_r.own_control_id <= pwdata[plgm_pkg::DATA_W-1:0];
        plgm_pkg::REG_VALUE_MASK: cfg_r.value_mask     <= pwdata[plgm_pkg::DATA_W-1:0];
        plgm_pkg::REG_REVERSE:    cfg_r.reverse_input  <= pwdata[0];
        plgm_pkg::REG_CURVE_PTS:  cfg_r.curve_points   <= pwdata[plgm_pkg::CP_W-1:0];
        plgm_pkg::REG_MIN_TRAVEL: cfg_r.min_travel     <= pwdata[plgm_pkg::TRAVEL_W-1:0];
        plgm_pkg::REG_MAX_TRAVEL: cfg_r.max_travel     <= pwdata[plgm_pkg::TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      plgm_pkg::REG_OWN_ID:     prdata = plgm_pkg::APB_DW'(cfg_r.own_control_id);
      plgm_pkg::REG_VALUE_MASK: prdata = plgm_pkg::APB_DW'(cfg_r.value_mask);
      plgm_pkg::REG_REVERSE:    prdata = plgm_pkg::APB_DW'(cfg_r.reverse_input);
      plgm_pkg::REG_CURVE_PTS:  prdata = plgm_pkg::APB_DW'(cfg_r.curve_points);
      plgm_pkg::REG_MIN_TRAVEL: prdata = plgm_pkg::APB_DW'(cfg_r.min_travel);
      plgm_pkg::REG_MAX_TRAVEL: prdata = plgm_pkg::APB_DW'(cfg_r.max_travel);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> src/plgm_curve.sv
`timescale 1ns / 1ps

module plgm_curve (
  input  logic                  clk,
  input  logic                  wr_en,
  input  plgm_pkg::idx_t        wr_addr,
  input  plgm_pkg::data_t       wr_in,
  input  plgm_pkg::data_t       wr_out,
  input  plgm_pkg::idx_t        rd_addr,
  output plgm_pkg::data_t       rd_in,
  output plgm_pkg::data_t       rd_out
);

  plgm_pkg::data_t in_mem  [plgm_pkg::CURVE_MAX];
  plgm_pkg::data_t out_mem [plgm_pkg::CURVE_MAX];
  plgm_pkg::data_t rd_in_r;
  plgm_pkg::data_t rd_out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      in_mem[wr_addr]  <= wr_in;
      out_mem[wr_addr] <= wr_out;
    end
  end

  // Both tables share one address, so one lookup returns a whole calibration point.
  always_ff @(posedge clk) begin
    rd_in_r  <= in_mem[rd_addr];
    rd_out_r <= out_mem[rd_addr];
  end

  assign rd_in  = rd_in_r;
  assign rd_out = rd_out_r;

endmodule

>>> src/plgm_muldiv.sv
`timescale 1ns / 1ps

module plgm_muldiv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plgm_pkg::md_req_t    req,
  output plgm_pkg::md_rsp_t    rsp
);

  localparam logic [2:0] MD_IDLE = 3'd0;
  localparam logic [2:0] MD_MUL  = 3'd1;
  localparam logic [2:0] MD_ABS  = 3'd2;
  localparam logic [2:0] MD_DIV  = 3'd3;
  localparam logic [2:0] MD_FIN  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  plgm_pkg::mdcnt_t        cnt_r;
  plgm_pkg::opd_t          a_r, b_r;
  plgm_pkg::data_t         div_r;
  plgm_pkg::prod_t         prod_r;
  plgm_pkg::prod_t         prod_neg;
  logic                    neg_r;
  plgm_pkg::mag_t          dq_r;
  plgm_pkg::data_t         rem_r;
  logic [plgm_pkg::DATA_W:0] trial;
  logic [plgm_pkg::DATA_W:0] trial_sub;
  logic                    q_bit;
  plgm_pkg::data_t         quot_r;
  logic                    done_r;

  assign prod_neg  = -prod_r;
  assign trial     = {rem_r, dq_r[plgm_pkg::MAG_W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign q_bit     = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_MUL;
      MD_MUL:  state_nxt = MD_ABS;
      MD_ABS:  state_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == plgm_pkg::mdcnt_t'(plgm_pkg::MAG_W - 1)) state_nxt = MD_FIN;
      MD_FIN:  state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == MD_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        a_r   <= req.op_a;
        b_r   <= req.op_b;
        div_r <= req.divisor;
      end
      MD_MUL: begin
        prod_r <= a_r * b_r;
      end
      MD_ABS: begin
        neg_r <= prod_r[plgm_pkg::PROD_W-1];
        dq_r  <= prod_r[plgm_pkg::PROD_W-1] ? prod_neg[plgm_pkg::MAG_W-1:0]
                                           : prod_r[plgm_pkg::MAG_W-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      MD_DIV: begin
        // One restoring step: the dividend shifts out at the top while the
        // quotient fills in at the bottom of the same register.
        rem_r <= q_bit ? trial_sub[plgm_pkg::DATA_W-1:0] : trial[plgm_pkg::DATA_W-1:0];
        dq_r  <= {dq_r[plgm_pkg::MAG_W-2:0], q_bit};
        cnt_r <= cnt_r + 1'b1;
      end
      MD_FIN: begin
        // Truncation toward zero: divide magnitudes, then restore the sign.
        quot_r <= neg_r ? -dq_r[plgm_pkg::DATA_W-1:0] : dq_r[plgm_pkg::DATA_W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
